/* src/scd_pkg.sv */
`timescale 1ns / 1ps

package scd_pkg;

    // Width of the shared serial divider and of all rate values.
    localparam int DIV_W = 32;

    // Source clock frequency after reset, in hertz.
    localparam logic [31:0] SRC_CLK_RESET = 32'd100_000_000;

    // Ratio below which the high-speed divider is used.
    localparam logic [31:0] HS_RATIO_LIMIT = 32'd32;

    // Divider code range.
    localparam logic [5:0] HS_DIV_FIRST = 6'd9;
    localparam logic [5:0] DIV_LAST     = 6'h3F;
    localparam logic [5:0] LOW_MASK     = 6'h1F;

    // Prescalers of normal mode, as shift amounts (divide by 16 and by 128).
    localparam int PRESCALE_SMALL_SH = 4;
    localparam int PRESCALE_BIG_SH   = 7;

    // Enable bit of the high-speed control word.
    localparam logic [15:0] HS_ENABLE = 16'h8000;

    typedef struct packed {
        logic [31:0] target_hz;
        logic [31:0] fallback_hz;
        logic        clock_phase;
        logic        clock_polarity;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  ctrl_word;
        logic [15:0] ctrl2_word;
        logic [31:0] achieved_hz;
        logic        rate_error;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RATIO,
        S_RATIO_WAIT,
        S_CAND,
        S_CAND_WAIT,
        S_DIFF,
        S_UPDATE,
        S_OUT
    } t_state;

endpackage

/* src/scd_divider.sv */
`timescale 1ns / 1ps

module scd_divider import scd_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DIV_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quo;
    logic [DIV_W-1:0] r_dsr;
    logic [CNT_W-1:0] r_cnt;
    logic             r_done;

    logic [DIV_W:0]   w_trial;
    logic [DIV_W:0]   w_sub;
    logic             w_borrow;

    // One restoring step: bring in the next dividend bit and try a subtract.
    assign w_trial  = {r_rem, r_quo[DIV_W-1]};
    assign w_sub    = w_trial - {1'b0, r_dsr};
    assign w_borrow = w_sub[DIV_W];

    // Step counter and completion pulse.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_cnt <= CNT_W'(DIV_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

    // Remainder and quotient shift registers; the quotient shifts in as the
    // dividend shifts out.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_cnt != '0) begin
            if (w_borrow) begin
                r_rem <= w_trial[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b0};
            end else begin
                r_rem <= w_sub[DIV_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], 1'b1};
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* src/spi_clock_divider_search.sv */
`timescale 1ns / 1ps
// When both rates are zero an accepted item goes straight to the output as an error;
// otherwise the ratio test runs first and then one candidate after another, 55
// candidates in high-speed mode (codes 9 to 63) and 64 in normal mode (codes 0 to 63).
// Throughput: one item at a time; each candidate needs a 32-step serial division.
// Reset (synchronous, active low) returns to idle, empties the output register and
// sets the source clock register to 100 MHz.

module spi_clock_divider_search import scd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);

    t_state      r_state, n_state;
    logic [31:0] r_src_clk;
    logic [31:0] r_target, n_target;
    logic        r_cpha, n_cpha;
    logic        r_cpol, n_cpol;
    logic        r_err, n_err;
    logic        r_hs, n_hs;
    logic        r_first, n_first;
    logic [5:0]  r_code, n_code;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_diff, n_diff;
    logic [31:0] r_best_diff, n_best_diff;
    logic [31:0] r_best_rate, n_best_rate;
    logic [5:0]  r_best_code, n_best_code;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out_item, n_out_item;

    logic             w_div_start;
    logic [DIV_W-1:0] w_dividend;
    logic [DIV_W-1:0] w_divisor;
    logic             w_div_done;
    logic [DIV_W-1:0] w_quotient;
    logic [31:0]      w_eff_target;
    logic [5:0]       w_low_plus;
    logic [6:0]       w_code_plus;
    logic [6:0]       w_best_plus;
    t_out_item        w_result;

    scd_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Source clock register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_clk <= SRC_CLK_RESET;
        end else if (i_cfg_wr_en) begin
            r_src_clk <= i_cfg_wr_data;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_target    <= n_target;
        r_cpha      <= n_cpha;
        r_cpol      <= n_cpol;
        r_err       <= n_err;
        r_hs        <= n_hs;
        r_first     <= n_first;
        r_code      <= n_code;
        r_rate      <= n_rate;
        r_diff      <= n_diff;
        r_best_diff <= n_best_diff;
        r_best_rate <= n_best_rate;
        r_best_code <= n_best_code;
        r_out_item  <= n_out_item;
    end

    // Helper values for the effective target, the candidate divisors and the high-speed word.
    assign w_eff_target = (i_in_item.target_hz != 32'd0) ? i_in_item.target_hz
                                                         : i_in_item.fallback_hz;
    assign w_low_plus   = (r_code & LOW_MASK) + 6'd1;
    assign w_code_plus  = {1'b0, r_code} + 7'd1;
    assign w_best_plus  = {1'b0, r_best_code} + 7'd1;

    // Result item built from the best candidate found, or an error item for a zero target.
    always_comb begin
        w_result = '0;
        if (r_err) begin
            w_result.rate_error = 1'b1;
        end else if (r_hs) begin
            w_result.ctrl_word   = {r_cpha, r_cpol, 6'd0};
            w_result.ctrl2_word  = HS_ENABLE | (16'(w_best_plus[6:1]) << 6)
                                 | 16'(r_best_code);
            w_result.achieved_hz = r_best_rate;
        end else begin
            w_result.ctrl_word   = {r_cpha, r_cpol, r_best_code};
            w_result.achieved_hz = r_best_rate;
        end
    end

    // Sequencer: ratio test, then one division, difference and compare per
    // candidate.
    always_comb begin
        n_state     = r_state;
        n_target    = r_target;
        n_cpha      = r_cpha;
        n_cpol      = r_cpol;
        n_err       = r_err;
        n_hs        = r_hs;
        n_first     = r_first;
        n_code      = r_code;
        n_rate      = r_rate;
        n_diff      = r_diff;
        n_best_diff = r_best_diff;
        n_best_rate = r_best_rate;
        n_best_code = r_best_code;
        n_out_item  = r_out_item;
        n_out_valid = r_out_valid && i_out_stall;
        w_div_start = 1'b0;
        w_dividend  = r_src_clk;
        w_divisor   = r_target;
        o_in_stall  = 1'b1;

        case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    n_target = w_eff_target;
                    n_cpha   = i_in_item.clock_phase;
                    n_cpol   = i_in_item.clock_polarity;
                    n_err    = (w_eff_target == 32'd0);
                    n_state  = (w_eff_target == 32'd0) ? S_OUT : S_RATIO;
                end
            end
            S_RATIO: begin
                w_div_start = 1'b1;
                n_state     = S_RATIO_WAIT;
            end
            S_RATIO_WAIT: begin
                if (w_div_done) begin
                    n_hs    = (w_quotient < HS_RATIO_LIMIT);
                    n_code  = (w_quotient < HS_RATIO_LIMIT) ? HS_DIV_FIRST : 6'd0;
                    n_first = 1'b1;
                    n_state = S_CAND;
                end
            end
            S_CAND: begin
                w_div_start = 1'b1;
                if (r_hs) begin
                    w_dividend = r_src_clk;
                    w_divisor  = DIV_W'(w_code_plus);
                end else begin
                    w_dividend = r_code[5] ? (r_src_clk >> PRESCALE_BIG_SH)
                                           : (r_src_clk >> PRESCALE_SMALL_SH);
                    w_divisor  = DIV_W'({w_low_plus, 1'b0});
                end
                n_state = S_CAND_WAIT;
            end
            S_CAND_WAIT: begin
                if (w_div_done) begin
                    n_rate  = w_quotient;
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_diff  = (r_target >= r_rate) ? (r_target - r_rate) : (r_rate - r_target);
                n_state = S_UPDATE;
            end
            S_UPDATE: begin
                // Strict compare keeps the earlier candidate on a tie.
                if (r_first || (r_diff < r_best_diff)) begin
                    n_first     = 1'b0;
                    n_best_diff = r_diff;
                    n_best_rate = r_rate;
                    n_best_code = r_code;
                end
                if (r_code == DIV_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_code  = r_code + 6'd1;
                    n_state = S_CAND;
                end
            end
            S_OUT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_item  = w_result;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The divider only finishes while the sequencer waits for it.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_RATIO_WAIT || r_state == S_CAND_WAIT))
        else $error("divider finished outside a wait state");

    // High-speed candidates never start below the first high-speed divider.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CAND && r_hs) |-> (r_code >= HS_DIV_FIRST))
        else $error("high-speed candidate below first divider");

    // An error item carries no setting.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.rate_error) |->
        (o_out_item.ctrl_word == 8'd0 && o_out_item.ctrl2_word == 16'd0 &&
         o_out_item.achieved_hz == 32'd0))
        else $error("error item with non-zero setting");

    // An accepted item always leaves the idle state.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> (r_state != S_IDLE))
        else $error("accepted item did not start a search");

endmodule
